// ===== sv/mer_pkg.sv =====
// shared types and constants for the midpoint ellipse rasterizer
// no dependencies; imported by mer_ctrl, mer_datapath and midpoint_ellipse_raster
package mer_pkg;

   localparam int PIX_W   = 14;
   localparam int COLOR_W = 24;

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_STEP  = 1'b1
   } cmd_type;

   typedef enum logic [3:0] {
      DP_NONE,
      DP_LOAD,
      DP_STEP,
      DP_SQ_RX,
      DP_SQ_RY,
      DP_START_P,
      DP_START_D,
      DP_MUL_X,
      DP_MUL_Y,
      DP_STEP_D,
      DP_R2_T,
      DP_R2_A,
      DP_R2_B,
      DP_R2_C,
      DP_R2_D,
      DP_R2_E
   } dp_op_type;

   typedef struct packed {
      logic lt;
      logic region2;
      logic active;
      logic emit_free;
   } dp_status_type;

endpackage

// ===== sv/mer_ctrl.sv =====
// sequencer for the ellipse rasterizer: request handshake and datapath operation order
// depends on mer_pkg
module mer_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_command,
   output logic                   req_ready,
   input  mer_pkg::dp_status_type status,
   output mer_pkg::dp_op_type     op
);
   import mer_pkg::*;

   typedef enum logic [3:0] {
      S_WAIT,
      S_SQ_RX,
      S_SQ_RY,
      S_ST_P,
      S_ST_D,
      S_MX,
      S_MY,
      S_SD,
      S_R2T,
      S_R2A,
      S_R2B,
      S_R2C,
      S_R2D,
      S_R2E
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff == S_WAIT) && status.emit_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      op       = DP_NONE;
      case (state_ff)
         S_WAIT: begin
            if (accept) begin
               if (req_command == CMD_START) begin
                  op       = DP_LOAD;
                  state_in = S_SQ_RX;
               end else if (status.active) begin
                  op       = DP_STEP;
                  state_in = S_MX;
               end
            end
         end
         S_SQ_RX: begin
            op       = DP_SQ_RX;
            state_in = S_SQ_RY;
         end
         S_SQ_RY: begin
            op       = DP_SQ_RY;
            state_in = S_ST_P;
         end
         S_ST_P: begin
            op       = DP_START_P;
            state_in = S_ST_D;
         end
         S_ST_D: begin
            op       = DP_START_D;
            state_in = status.lt ? S_WAIT : S_R2T;
         end
         S_MX: begin
            op       = DP_MUL_X;
            state_in = S_MY;
         end
         S_MY: begin
            op       = DP_MUL_Y;
            state_in = S_SD;
         end
         S_SD: begin
            op       = DP_STEP_D;
            state_in = (status.region2 || status.lt) ? S_WAIT : S_R2T;
         end
         S_R2T: begin
            op       = DP_R2_T;
            state_in = S_R2A;
         end
         S_R2A: begin
            op       = DP_R2_A;
            state_in = S_R2B;
         end
         S_R2B: begin
            op       = DP_R2_B;
            state_in = S_R2C;
         end
         S_R2C: begin
            op       = DP_R2_C;
            state_in = S_R2D;
         end
         S_R2D: begin
            op       = DP_R2_D;
            state_in = S_R2E;
         end
         S_R2E: begin
            op       = DP_R2_E;
            state_in = S_WAIT;
         end
         default: begin
            state_in = S_WAIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_WAIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/mer_datapath.sv =====
// datapath of the ellipse rasterizer: point and decision registers, shared multiplier,
// four-pixel mirror emitter with output register; depends on mer_pkg
module mer_datapath #(
   parameter int RADIUS_BITS = 11,
   parameter int COORD_BITS  = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mer_pkg::dp_op_type                  op,
   output mer_pkg::dp_status_type              status,
   input  logic [COORD_BITS-1:0]               req_center_x,
   input  logic [COORD_BITS-1:0]               req_center_y,
   input  logic [RADIUS_BITS-1:0]              req_radius_x,
   input  logic [RADIUS_BITS-1:0]              req_radius_y,
   input  logic [mer_pkg::COLOR_W-1:0]         req_paint_color,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [mer_pkg::PIX_W-1:0]    rsp_pixel_x,
   output logic signed [mer_pkg::PIX_W-1:0]    rsp_pixel_y,
   output logic [mer_pkg::COLOR_W-1:0]         rsp_pixel_color,
   output logic                                rsp_last_of_point,
   output logic                                rsp_ellipse_done
);
   import mer_pkg::*;

   localparam int XW  = RADIUS_BITS + 1;
   localparam int YW  = RADIUS_BITS + 2;
   localparam int SQW = 2 * RADIUS_BITS;
   localparam int DW  = 4 * RADIUS_BITS + 4;
   localparam int MA  = 2 * RADIUS_BITS + 1;
   localparam int MB  = 2 * RADIUS_BITS + 5;

   logic [COORD_BITS-1:0]  cx_ff, cx_in, cy_ff, cy_in;
   logic [COLOR_W-1:0]     color_ff, color_in;
   logic [RADIUS_BITS-1:0] rad_x_ff, rad_x_in, rad_y_ff, rad_y_in;
   logic [SQW-1:0]         rx2_ff, rx2_in, ry2_ff, ry2_in;
   logic [XW-1:0]          x_ff, x_in, ex_ff, ex_in;
   logic signed [YW-1:0]   y_ff, y_in, ey_ff, ey_in;
   logic signed [DW-1:0]   dec_ff, dec_in, prod_ff, prod_in, cmp_ff, cmp_in;
   logic                   region2_ff, region2_in, active_ff, active_in;
   logic                   diag_ff, diag_in, done_ff, done_in;
   logic                   pend_ff, pend_in;
   logic [1:0]             idx_ff, idx_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [PIX_W-1:0]  rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [COLOR_W-1:0]       rsp_color_ff, rsp_color_in;
   logic                     rsp_last_ff, rsp_last_in, rsp_done_ff, rsp_done_in;

   logic signed [MA-1:0]     mul_a;
   logic signed [MB-1:0]     mul_b;
   logic signed [MA+MB-1:0]  mul_p;
   logic                     mul_en;
   logic [XW:0]              t_val;
   logic signed [YW-1:0]     ym1;
   logic signed [DW-1:0]     rx2_e, ry2_e;
   logic                     diag_now, incx, decy, load;
   logic signed [YW-1:0]     y_step;
   logic signed [PIX_W-1:0]  cxp, cyp, exp_v, eyp;

   assign t_val = {x_ff, 1'b1};
   assign ym1   = y_ff - YW'(1);
   assign rx2_e = DW'(rx2_ff);
   assign ry2_e = DW'(ry2_ff);

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (op)
         DP_SQ_RX: begin
            mul_a = MA'(rad_x_ff);
            mul_b = MB'(rad_x_ff);
         end
         DP_SQ_RY: begin
            mul_a = MA'(rad_y_ff);
            mul_b = MB'(rad_y_ff);
         end
         DP_START_P, DP_MUL_Y: begin
            mul_a = MA'(rx2_ff);
            mul_b = MB'(y_ff);
         end
         DP_MUL_X: begin
            mul_a = MA'(ry2_ff);
            mul_b = MB'(x_ff);
         end
         DP_R2_T: begin
            mul_a = MA'(t_val);
            mul_b = MB'(t_val);
         end
         DP_R2_A: begin
            mul_a = MA'(ry2_ff);
            mul_b = prod_ff[MB-1:0];
         end
         DP_R2_B: begin
            mul_a = MA'(ym1);
            mul_b = MB'(ym1);
         end
         DP_R2_C: begin
            mul_a = MA'(rx2_ff);
            mul_b = prod_ff[MB-1:0];
         end
         DP_R2_D: begin
            mul_a = MA'(rx2_ff);
            mul_b = MB'(ry2_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p  = mul_a * mul_b;
   assign mul_en = op inside {DP_SQ_RX, DP_SQ_RY, DP_START_P, DP_MUL_Y, DP_MUL_X,
                              DP_R2_T, DP_R2_A, DP_R2_B, DP_R2_C, DP_R2_D};

   // next point: region one moves x, region two moves y, diagonal moves both
   assign diag_now = region2_ff ? !(!dec_ff[DW-1] && (dec_ff != '0)) : !dec_ff[DW-1];
   assign y_step   = y_ff - YW'(region2_ff || diag_now);
   assign incx     = !region2_ff || diag_ff;
   assign decy     = region2_ff || diag_ff;
   assign load     = pend_ff && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      color_in   = color_ff;
      rad_x_in   = rad_x_ff;
      rad_y_in   = rad_y_ff;
      rx2_in     = rx2_ff;
      ry2_in     = ry2_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      ex_in      = ex_ff;
      ey_in      = ey_ff;
      dec_in     = dec_ff;
      cmp_in     = cmp_ff;
      region2_in = region2_ff;
      active_in  = active_ff;
      diag_in    = diag_ff;
      done_in    = done_ff;
      prod_in    = mul_en ? mul_p[DW-1:0] : prod_ff;
      pend_in    = pend_ff;
      idx_in     = idx_ff;
      if (load) begin
         idx_in = idx_ff + 2'd1;
         if (idx_ff == 2'd3) begin
            pend_in = 1'b0;
         end
      end
      case (op)
         DP_LOAD: begin
            cx_in      = req_center_x;
            cy_in      = req_center_y;
            color_in   = req_paint_color;
            rad_x_in   = req_radius_x;
            rad_y_in   = req_radius_y;
            x_in       = '0;
            y_in       = YW'(req_radius_y);
            region2_in = 1'b0;
            active_in  = 1'b1;
         end
         DP_STEP: begin
            ex_in     = x_ff;
            ey_in     = y_ff;
            diag_in   = diag_now;
            x_in      = x_ff + XW'(!region2_ff || diag_now);
            y_in      = y_step;
            done_in   = region2_ff && y_step[YW-1];
            active_in = !(region2_ff && y_step[YW-1]);
            pend_in   = 1'b1;
            idx_in    = 2'd0;
         end
         DP_SQ_RY: begin
            rx2_in = prod_ff[SQW-1:0];
         end
         DP_START_P: begin
            ry2_in = prod_ff[SQW-1:0];
            cmp_in = '0;
         end
         DP_START_D: begin
            dec_in = (ry2_e <<< 2) - (prod_ff <<< 2) + rx2_e;
         end
         DP_MUL_Y: begin
            cmp_in = prod_ff;
         end
         DP_STEP_D: begin
            dec_in = dec_ff + (incx ? (cmp_ff <<< 3) : '0) - (decy ? (prod_ff <<< 3) : '0)
                     + ((region2_ff ? rx2_e : ry2_e) <<< 2);
         end
         DP_R2_B: begin
            dec_in = prod_ff;
         end
         DP_R2_D: begin
            dec_in = dec_ff + (prod_ff <<< 2);
         end
         DP_R2_E: begin
            dec_in     = dec_ff - (prod_ff <<< 2);
            region2_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // mirrored pixel select
   assign cxp   = PIX_W'(cx_ff);
   assign cyp   = PIX_W'(cy_ff);
   assign exp_v = PIX_W'(ex_ff);
   assign eyp   = PIX_W'(ey_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_color_in = rsp_color_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_done_in  = rsp_done_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_color_in = color_ff;
         rsp_last_in  = (idx_ff == 2'd3);
         rsp_done_in  = (idx_ff == 2'd3) && done_ff;
         case (idx_ff)
            2'd0: begin
               rsp_x_in = cxp + exp_v;
               rsp_y_in = cyp + eyp;
            end
            2'd1: begin
               rsp_x_in = cxp - exp_v;
               rsp_y_in = cyp + eyp;
            end
            2'd2: begin
               rsp_x_in = cxp - exp_v;
               rsp_y_in = cyp - eyp;
            end
            default: begin
               rsp_x_in = cxp + exp_v;
               rsp_y_in = cyp - eyp;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region2_ff   <= 1'b0;
         active_ff    <= 1'b0;
         pend_ff      <= 1'b0;
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         region2_ff   <= region2_in;
         active_ff    <= active_in;
         pend_ff      <= pend_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      color_ff     <= color_in;
      rad_x_ff     <= rad_x_in;
      rad_y_ff     <= rad_y_in;
      rx2_ff       <= rx2_in;
      ry2_ff       <= ry2_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      ex_ff        <= ex_in;
      ey_ff        <= ey_in;
      dec_ff       <= dec_in;
      cmp_ff       <= cmp_in;
      prod_ff      <= prod_in;
      diag_ff      <= diag_in;
      done_ff      <= done_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_color_ff <= rsp_color_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_done_ff  <= rsp_done_in;
   end

   assign status.lt        = cmp_ff < prod_ff;
   assign status.region2   = region2_ff;
   assign status.active    = active_ff;
   assign status.emit_free = !pend_ff || (load && (idx_ff == 2'd3));

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_x       = rsp_x_ff;
   assign rsp_pixel_y       = rsp_y_ff;
   assign rsp_pixel_color   = rsp_color_ff;
   assign rsp_last_of_point = rsp_last_ff;
   assign rsp_ellipse_done  = rsp_done_ff;

endmodule

// ===== sv/midpoint_ellipse_raster.sv =====
// top level of the midpoint ellipse rasterizer
// depends on mer_pkg, mer_ctrl and mer_datapath
//
// axis-aligned midpoint ellipse rasterizer. a start request (command 0) loads center,
// radii and color, then squares the radii and sets up the region-one decision value;
// it gives no pixels. each step request (command 1) then gives four mirrored pixels
// of the current point, in the order (cx+x,cy+y), (cx-x,cy+y), (cx-x,cy-y),
// (cx+x,cy-y), and advances the point. a step uses two products on the single shared
// multiplier, and no new request is taken until the four-pixel emitter is free; the
// step on which the point crosses into region two also runs the region-two setup
// products on that multiplier, and so does a start whose first point already lies
// past the region boundary. the fourth pixel of every step carries last_of_point, the
// fourth pixel of the final point carries ellipse_done, after which the block is idle.
// a step while idle is taken and dropped. pixels on an axis come out twice.
// coordinates wrap to 14 bits.
module midpoint_ellipse_raster #(
   parameter int RADIUS_BITS = 11,
   parameter int COORD_BITS  = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_command,
   input  logic [COORD_BITS-1:0]            req_center_x,
   input  logic [COORD_BITS-1:0]            req_center_y,
   input  logic [RADIUS_BITS-1:0]           req_radius_x,
   input  logic [RADIUS_BITS-1:0]           req_radius_y,
   input  logic [mer_pkg::COLOR_W-1:0]      req_paint_color,
   // pixel channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [mer_pkg::PIX_W-1:0] rsp_pixel_x,
   output logic signed [mer_pkg::PIX_W-1:0] rsp_pixel_y,
   output logic [mer_pkg::COLOR_W-1:0]      rsp_pixel_color,
   output logic                             rsp_last_of_point,
   output logic                             rsp_ellipse_done
);
   import mer_pkg::*;

   dp_op_type     op;
   dp_status_type status;

   // sequencer: request handshake and operation order
   mer_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_ready   (req_ready),
      .status      (status),
      .op          (op)
   );

   // point state, decision arithmetic and pixel output register
   mer_datapath #(
      .RADIUS_BITS (RADIUS_BITS),
      .COORD_BITS  (COORD_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .op                (op),
      .status            (status),
      .req_center_x      (req_center_x),
      .req_center_y      (req_center_y),
      .req_radius_x      (req_radius_x),
      .req_radius_y      (req_radius_y),
      .req_paint_color   (req_paint_color),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pixel_x       (rsp_pixel_x),
      .rsp_pixel_y       (rsp_pixel_y),
      .rsp_pixel_color   (rsp_pixel_color),
      .rsp_last_of_point (rsp_last_of_point),
      .rsp_ellipse_done  (rsp_ellipse_done)
   );

endmodule

// ===== tb/ellipse_pixel_checker.sv =====
// pixel checker for the midpoint ellipse rasterizer: tracks the ellipse state on
// every accepted request and compares each pixel that leaves the block
// depends on mer_pkg
module ellipse_pixel_checker #(
   parameter int RADIUS_BITS = 11,
   parameter int COORD_BITS  = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic                             req_command,
   input  logic [COORD_BITS-1:0]            req_center_x,
   input  logic [COORD_BITS-1:0]            req_center_y,
   input  logic [RADIUS_BITS-1:0]           req_radius_x,
   input  logic [RADIUS_BITS-1:0]           req_radius_y,
   input  logic [mer_pkg::COLOR_W-1:0]      req_paint_color,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic signed [mer_pkg::PIX_W-1:0] rsp_pixel_x,
   input  logic signed [mer_pkg::PIX_W-1:0] rsp_pixel_y,
   input  logic [mer_pkg::COLOR_W-1:0]      rsp_pixel_color,
   input  logic                             rsp_last_of_point,
   input  logic                             rsp_ellipse_done,
   output int                               fail_count,
   output int                               pixels_owed
);
   import mer_pkg::*;

   typedef struct {
      logic signed [PIX_W-1:0] x;
      logic signed [PIX_W-1:0] y;
      logic [COLOR_W-1:0]      color;
      logic                    last;
      logic                    done;
   } pixel_type;

   pixel_type due_pixels[$];
   int        errors = 0;

   // ellipse state, decision value scaled by four
   logic [COORD_BITS-1:0] center_x_r, center_y_r;
   logic [COLOR_W-1:0]    color_r;
   longint                rx_sq, ry_sq, pt_x, pt_y, decision;
   bit                    in_region_two, drawing;

   initial begin
      fail_count  = 0;
      pixels_owed = 0;
   end

   task automatic enter_region_two_if_due();
      longint t, ym1;
      if (!in_region_two && ry_sq * pt_x >= rx_sq * pt_y) begin
         t   = 2 * pt_x + 1;
         ym1 = pt_y - 1;
         decision = ry_sq * t * t + 4 * rx_sq * ym1 * ym1 - 4 * rx_sq * ry_sq;
         in_region_two = 1'b1;
      end
   endtask

   task automatic owe_pixel(input longint px, input longint py, input bit last,
                            input bit done);
      pixel_type p;
      p.x     = px[PIX_W-1:0];
      p.y     = py[PIX_W-1:0];
      p.color = color_r;
      p.last  = last;
      p.done  = done;
      due_pixels.push_back(p);
   endtask

   task automatic trace_ellipse_request();
      longint rx, ry, x0, y0, cx, cy;
      bit     done;
      if (req_command == CMD_START) begin
         rx = req_radius_x;
         ry = req_radius_y;
         center_x_r = req_center_x;
         center_y_r = req_center_y;
         color_r    = req_paint_color;
         rx_sq = rx * rx;
         ry_sq = ry * ry;
         pt_x  = 0;
         pt_y  = ry;
         decision = 4 * ry_sq - 4 * rx_sq * ry + rx_sq;
         in_region_two = 1'b0;
         drawing       = 1'b1;
         enter_region_two_if_due();
      end else if (drawing) begin
         x0   = pt_x;
         y0   = pt_y;
         cx   = center_x_r;
         cy   = center_y_r;
         done = 1'b0;
         if (!in_region_two) begin
            pt_x = x0 + 1;
            if (decision < 0) begin
               decision += 8 * ry_sq * pt_x + 4 * ry_sq;
            end else begin
               pt_y = y0 - 1;
               decision += 8 * ry_sq * pt_x - 8 * rx_sq * pt_y + 4 * ry_sq;
            end
            enter_region_two_if_due();
         end else begin
            pt_y = y0 - 1;
            if (decision > 0) begin
               decision += 4 * rx_sq - 8 * rx_sq * pt_y;
            end else begin
               pt_x = x0 + 1;
               decision += 8 * ry_sq * pt_x - 8 * rx_sq * pt_y + 4 * rx_sq;
            end
            if (pt_y < 0) begin
               done    = 1'b1;
               drawing = 1'b0;
            end
         end
         owe_pixel(cx + x0, cy + y0, 1'b0, 1'b0);
         owe_pixel(cx - x0, cy + y0, 1'b0, 1'b0);
         owe_pixel(cx - x0, cy - y0, 1'b0, 1'b0);
         owe_pixel(cx + x0, cy - y0, 1'b1, done);
      end
   endtask

   always @(posedge clock) begin : watch
      pixel_type want;
      if (reset) begin
         due_pixels.delete();
         center_x_r    = '0;
         center_y_r    = '0;
         color_r       = '0;
         rx_sq         = 0;
         ry_sq         = 0;
         pt_x          = 0;
         pt_y          = 0;
         decision      = 0;
         in_region_two = 1'b0;
         drawing       = 1'b0;
      end else begin
         // pixels first, so one with nothing owed is caught
         if (rsp_valid && rsp_ready) begin
            if (due_pixels.size() == 0) begin
               $error("pixel (%0d,%0d) with nothing owed", rsp_pixel_x, rsp_pixel_y);
               errors++;
            end else begin
               want = due_pixels.pop_front();
               if (rsp_pixel_x !== want.x) begin
                  $error("pixel_x expected %0d got %0d", want.x, rsp_pixel_x);
                  errors++;
               end
               if (rsp_pixel_y !== want.y) begin
                  $error("pixel_y expected %0d got %0d", want.y, rsp_pixel_y);
                  errors++;
               end
               if (rsp_pixel_color !== want.color) begin
                  $error("pixel_color expected %h got %h", want.color, rsp_pixel_color);
                  errors++;
               end
               if (rsp_last_of_point !== want.last) begin
                  $error("last_of_point expected %0b got %0b", want.last,
                         rsp_last_of_point);
                  errors++;
               end
               if (rsp_ellipse_done !== want.done) begin
                  $error("ellipse_done expected %0b got %0b", want.done,
                         rsp_ellipse_done);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready) begin
            trace_ellipse_request();
         end
      end
      fail_count  <= errors;
      pixels_owed <= due_pixels.size();
   end

endmodule

// ===== tb/testbench.sv =====
// top of the midpoint ellipse rasterizer bench: clock, reset, request stimulus,
// pixel-side back pressure, watchdog and verdict
// depends on mer_pkg, midpoint_ellipse_raster and ellipse_pixel_checker
module testbench;
   import mer_pkg::*;

   localparam int RADIUS_W       = 11;
   localparam int COORD_W        = 12;
   localparam int TARGET_ITEMS   = 430;
   // last stretch of the run goes without any idling on either side
   localparam int CALM_AFTER     = 370;
   // long pixel-side hold, long enough to back the block up into its request side
   localparam int LONG_HOLD      = 300;
   localparam int HOLD_AFTER     = 120;
   // the longest wait without a handshake is the long pixel-side hold, so this leaves
   // a wide margin
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid       = 1'b0;
   logic                       req_ready;
   logic                       req_command     = 1'b0;
   logic [COORD_W-1:0]         req_center_x    = '0;
   logic [COORD_W-1:0]         req_center_y    = '0;
   logic [RADIUS_W-1:0]        req_radius_x    = '0;
   logic [RADIUS_W-1:0]        req_radius_y    = '0;
   logic [COLOR_W-1:0]         req_paint_color = '0;

   logic                       rsp_valid;
   logic                       rsp_ready       = 1'b0;
   logic signed [PIX_W-1:0]    rsp_pixel_x;
   logic signed [PIX_W-1:0]    rsp_pixel_y;
   logic [COLOR_W-1:0]         rsp_pixel_color;
   logic                       rsp_last_of_point;
   logic                       rsp_ellipse_done;

   int fail_count;
   int pixels_owed;
   int drawn_items    = 0;    // requests that start or advance an ellipse
   int stalled_cycles = 0;    // cycles since the last handshake on either side
   bit calm           = 1'b0; // no idling from here on
   bit long_hold_done = 1'b0;

   // 4 time unit clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   midpoint_ellipse_raster #(
      .RADIUS_BITS (RADIUS_W),
      .COORD_BITS  (COORD_W)
   ) uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_center_x      (req_center_x),
      .req_center_y      (req_center_y),
      .req_radius_x      (req_radius_x),
      .req_radius_y      (req_radius_y),
      .req_paint_color   (req_paint_color),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pixel_x       (rsp_pixel_x),
      .rsp_pixel_y       (rsp_pixel_y),
      .rsp_pixel_color   (rsp_pixel_color),
      .rsp_last_of_point (rsp_last_of_point),
      .rsp_ellipse_done  (rsp_ellipse_done)
   );

   // checker watches both channels, tracks the ellipse and counts mismatches
   ellipse_pixel_checker #(
      .RADIUS_BITS (RADIUS_W),
      .COORD_BITS  (COORD_W)
   ) checker_i (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_center_x      (req_center_x),
      .req_center_y      (req_center_y),
      .req_radius_x      (req_radius_x),
      .req_radius_y      (req_radius_y),
      .req_paint_color   (req_paint_color),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pixel_x       (rsp_pixel_x),
      .rsp_pixel_y       (rsp_pixel_y),
      .rsp_pixel_color   (rsp_pixel_color),
      .rsp_last_of_point (rsp_last_of_point),
      .rsp_ellipse_done  (rsp_ellipse_done),
      .fail_count        (fail_count),
      .pixels_owed       (pixels_owed)
   );

   // one request: an optional idle burst, then valid held with a steady payload
   // until the handshake. valid is only lowered inside the burst, so it never gets
   // two assignments in one step
   task automatic send_request(input cmd_type cmd, input logic [COORD_W-1:0] cx,
                               input logic [COORD_W-1:0] cy,
                               input logic [RADIUS_W-1:0] rx,
                               input logic [RADIUS_W-1:0] ry,
                               input logic [COLOR_W-1:0] color, input bit counted);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_center_x    <= cx;
      req_center_y    <= cy;
      req_radius_x    <= rx;
      req_radius_y    <= ry;
      req_paint_color <= color;
      do @(posedge clock); while (!req_ready);
      if (counted) drawn_items++;
   endtask

   // a step carries junk in the start fields, which the block must ignore
   task automatic send_step(input bit counted);
      send_request(CMD_STEP, COORD_W'($urandom), COORD_W'($urandom),
                   RADIUS_W'($urandom), RADIUS_W'($urandom), COLOR_W'($urandom),
                   counted);
   endtask

   // start an ellipse at a random place and color, then step it. a full ellipse never
   // needs more than rx+ry+1 steps; steps past that hit an idle block and don't count
   task automatic draw_ellipse(input logic [RADIUS_W-1:0] rx,
                               input logic [RADIUS_W-1:0] ry, input int steps);
      int k;
      int full;
      full = int'(rx) + int'(ry) + 1;
      send_request(CMD_START, COORD_W'($urandom), COORD_W'($urandom), rx, ry,
                   COLOR_W'($urandom), 1'b1);
      for (k = 0; k < steps; k++) send_step(k < full);
   endtask

   // pixel side: short random stalls, one long hold partway through, none at the end
   initial begin
      forever begin
         @(posedge clock);
         if (!long_hold_done && drawn_items >= HOLD_AFTER) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold_done = 1'b1;
            rsp_ready <= 1'b1;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog: counts cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stalled_cycles <= 0;
      else
         stalled_cycles <= stalled_cycles + 1;
   end

   initial begin
      wait (stalled_cycles >= WATCHDOG_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int                  pick;
      int                  steps;
      logic [RADIUS_W-1:0] rx;
      logic [RADIUS_W-1:0] ry;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed part
      // step right out of reset: the block is idle, nothing comes out
      send_step(1'b0);
      // zero radii at the origin: one point drawn four times
      send_request(CMD_START, 12'd0, 12'd0, 11'd0, 11'd0, 24'h000000, 1'b1);
      send_step(1'b1);
      send_step(1'b0);
      // zero horizontal radius at the far corner, region two from the start
      send_request(CMD_START, 12'hFFF, 12'hFFF, 11'd0, 11'd3, 24'hFFFFFF, 1'b1);
      repeat (4) send_step(1'b1);
      send_step(1'b0);
      // zero vertical radius: single point, done on the first step
      send_request(CMD_START, 12'd100, 12'd200, 11'd3, 11'd0, 24'hA5A5A5, 1'b1);
      send_step(1'b1);
      send_step(1'b0);
      // largest radii, a few steps, then a restart in the middle of the ellipse
      send_request(CMD_START, 12'd2048, 12'd2048, 11'h7FF, 11'h7FF, 24'h123456, 1'b1);
      repeat (3) send_step(1'b1);
      send_request(CMD_START, 12'd7, 12'd4000, 11'd2, 11'd1, 24'h00FF00, 1'b1);
      repeat (4) send_step(1'b1);
      send_step(1'b0);

      // random part: mostly whole small ellipses, some cut short by a restart,
      // some huge radii that are only stepped a little, and stray steps
      while (drawn_items < TARGET_ITEMS) begin
         calm = (drawn_items >= CALM_AFTER);
         pick = int'($urandom_range(0, 99));
         if (pick < 6) begin
            send_step(1'b0);
         end else if (pick < 18) begin
            rx = RADIUS_W'($urandom);
            ry = RADIUS_W'($urandom);
            draw_ellipse(rx, ry, int'($urandom_range(1, 10)));
         end else begin
            rx = RADIUS_W'($urandom_range(0, 20));
            ry = RADIUS_W'($urandom_range(0, 20));
            if ($urandom_range(0, 6) == 0)
               steps = int'($urandom_range(0, int'(rx) + int'(ry)));
            else
               steps = int'(rx) + int'(ry) + 1 + int'($urandom_range(0, 2));
            draw_ellipse(rx, ry, steps);
         end
      end
      req_valid <= 1'b0;

      // let the checker see the last request, wait for every owed pixel, then
      // a little longer in case something extra comes out
      @(posedge clock);
      while (pixels_owed != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && pixels_owed == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/mer_pkg.sv
sv/mer_ctrl.sv
sv/mer_datapath.sv
sv/midpoint_ellipse_raster.sv
tb/ellipse_pixel_checker.sv
tb/testbench.sv
